[sv/dsed_pkg.sv]
`default_nettype none
package dsed_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_WIDTH   = 2048;
  localparam int ADDR_BITS   = $clog2(MAX_WIDTH);
  localparam int COL_BITS    = ADDR_BITS;
  localparam int ROW_BITS    = 12;
  localparam int OUT_POS_BITS = 11;
  localparam int CFG_BITS    = 12;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);
  localparam logic [CFG_BITS-1:0] DIM_MIN      = CFG_BITS'(3);
  localparam logic [CFG_BITS-1:0] WIDTH_MAX    = CFG_BITS'(MAX_WIDTH);

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  // one sample from each of the three layers at one pixel
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] above;
    logic signed [SAMPLE_BITS-1:0] middle;
    logic signed [SAMPLE_BITS-1:0] below;
  } triple_t;

  localparam int TRIPLE_BITS = $bits(triple_t);

  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
  } pos_t;

endpackage
`default_nettype wire

[sv/dog_scale_space_extremum_detect_top.sv]
`default_nettype none
// 3x3x3 extremum detector over three difference-of-gaussian layers
// pipeline: stage 1 holds an accepted word, the output register then holds its verdict
// throughput: one word per cycle while out_stall is low, set by the single-port-read line stores
// reset: rst_n synchronous, clears counters, window, pipeline valids, and sets
// width 640 and height 480; line stores are not cleared
module dog_scale_space_extremum_detect_top
  import dsed_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [CFG_BITS-1:0]           cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_layer_below,
  input  wire logic signed [SAMPLE_BITS-1:0] in_layer_middle,
  input  wire logic signed [SAMPLE_BITS-1:0] in_layer_above,
  input  wire logic                          in_frame_start,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_extremum_found,
  output logic                               out_centre_valid,
  output logic [OUT_POS_BITS-1:0]            out_centre_row,
  output logic [OUT_POS_BITS-1:0]            out_centre_column
);

  // configuration registers
  logic [CFG_BITS-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: stage 1 holds the input word while the line stores are read,
  // the output register holds the verdict; both advance together
  logic    in_accept;
  logic    s1_valid_r;
  logic    s1_adv;
  logic    out_valid_r;
  triple_t s1_cur_r;
  pos_t    s1_pos_r;
  pos_t    pos;
  triple_t cur;

  assign s1_adv    = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall  = s1_valid_r & ~s1_adv;
  assign in_accept = in_valid & ~in_stall;

  assign cur.below  = in_layer_below;
  assign cur.middle = in_layer_middle;
  assign cur.above  = in_layer_above;

  // position of the incoming pixel, frame start and wrap handled inside
  dsed_position u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (in_accept),
    .frame_start (in_frame_start),
    .width       (width_r),
    .height      (height_r),
    .pos         (pos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cur_r <= cur;
      s1_pos_r <= pos;
    end
  end

  // line stores: store 0 holds row-1, store 1 holds row-2
  // read when the word is taken, written when it leaves stage 1; the
  // store bypasses a same-address write so back-to-back frame starts work
  logic [TRIPLE_BITS-1:0] mid_raw, top_raw;
  triple_t                mid, top;

  dsed_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (TRIPLE_BITS)
  ) u_line0 (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_pos_r.col[ADDR_BITS-1:0]),
    .wdata (s1_cur_r),
    .re    (in_accept),
    .raddr (pos.col[ADDR_BITS-1:0]),
    .rdata (mid_raw)
  );

  dsed_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (TRIPLE_BITS)
  ) u_line1 (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_pos_r.col[ADDR_BITS-1:0]),
    .wdata (mid_raw),
    .re    (in_accept),
    .raddr (pos.col[ADDR_BITS-1:0]),
    .rdata (top_raw)
  );

  assign mid = triple_t'(mid_raw);
  assign top = triple_t'(top_raw);

  // window shift and 27-way compare
  triple_t new_col [3];
  logic    extremum;

  assign new_col[0] = top;
  assign new_col[1] = mid;
  assign new_col[2] = s1_cur_r;

  dsed_window u_win (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (s1_adv),
    .new_col  (new_col),
    .extremum (extremum)
  );

  // interior test: the incoming pixel must be at least two rows and columns in
  logic                interior;
  logic [ROW_BITS-1:0] row_m1;
  logic [COL_BITS-1:0] col_m1;

  assign interior = (s1_pos_r.row >= ROW_BITS'(2)) && (s1_pos_r.col >= COL_BITS'(2));
  assign row_m1   = s1_pos_r.row - 1'b1;
  assign col_m1   = s1_pos_r.col - 1'b1;

  // output register
  logic                    ext_r, cvalid_r;
  logic [OUT_POS_BITS-1:0] crow_r, ccol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      ext_r    <= interior & extremum;
      cvalid_r <= interior;
      crow_r   <= interior ? row_m1[OUT_POS_BITS-1:0] : '0;
      ccol_r   <= interior ? col_m1[OUT_POS_BITS-1:0] : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_extremum_found = ext_r;
  assign out_centre_valid   = cvalid_r;
  assign out_centre_row     = crow_r;
  assign out_centre_column  = ccol_r;

endmodule
`default_nettype wire

[sv/dsed_line_ram.sv]
`default_nettype none
module dsed_line_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // a read colliding with a write returns the new word
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata_r <= wdata;
      end else begin
        rdata_r <= mem[raddr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[sv/dsed_position.sv]
`default_nettype none
module dsed_position
  import dsed_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire logic                frame_start,
  input  wire logic [CFG_BITS-1:0] width,
  input  wire logic [CFG_BITS-1:0] height,
  output pos_t                     pos
);

  logic [COL_BITS-1:0] col_r, col_nxt;
  logic [ROW_BITS-1:0] row_r, row_nxt;
  logic [CFG_BITS-1:0] w_eff, h_eff;
  logic [COL_BITS-1:0] col_cur;
  logic [ROW_BITS-1:0] row_cur;
  logic [COL_BITS:0]   col_inc;
  logic [ROW_BITS:0]   row_inc;

  always_comb begin
    w_eff = width;
    if (width < DIM_MIN) begin
      w_eff = DIM_MIN;
    end else if (width > WIDTH_MAX) begin
      w_eff = WIDTH_MAX;
    end
    h_eff = (height < DIM_MIN) ? DIM_MIN : height;

    col_cur = frame_start ? '0 : col_r;
    row_cur = frame_start ? '0 : row_r;
    if ({1'b0, col_cur} >= w_eff) begin
      col_cur = '0;
    end
    if (row_cur >= h_eff) begin
      row_cur = '0;
    end

    col_inc = {1'b0, col_cur} + 1'b1;
    row_inc = {1'b0, row_cur} + 1'b1;
    col_nxt = col_inc[COL_BITS-1:0];
    row_nxt = row_cur;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = row_inc[ROW_BITS-1:0];
      if (row_inc >= {1'b0, h_eff}) begin
        row_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (adv) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign pos.col = col_cur;
  assign pos.row = row_cur;

endmodule
`default_nettype wire

[sv/dsed_window.sv]
`default_nettype none
module dsed_window
  import dsed_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    shift_en,
  input  wire triple_t new_col [3],
  output logic         extremum
);

  // two older columns per window row, index 0 oldest
  triple_t win_r [3][2];
  logic signed [SAMPLE_BITS-1:0] nb [27];
  logic signed [SAMPLE_BITS-1:0] centre;
  logic                          is_max;
  logic [26:0]                   fail;

  // window after the shift: old column 1, old column 2, new column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nb[9*r + 0] = win_r[r][0].below;
      nb[9*r + 1] = win_r[r][0].middle;
      nb[9*r + 2] = win_r[r][0].above;
      nb[9*r + 3] = win_r[r][1].below;
      nb[9*r + 4] = win_r[r][1].middle;
      nb[9*r + 5] = win_r[r][1].above;
      nb[9*r + 6] = new_col[r].below;
      nb[9*r + 7] = new_col[r].middle;
      nb[9*r + 8] = new_col[r].above;
    end
  end

  assign centre = win_r[1][1].middle;
  assign is_max = (centre > $signed(SAMPLE_BITS'(0)));

  always_comb begin
    for (int i = 0; i < 27; i++) begin
      fail[i] = is_max ? (nb[i] > centre) : (nb[i] < centre);
    end
  end

  assign extremum = ~|fail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= '0;
        win_r[r][1] <= '0;
      end
    end else if (shift_en) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= new_col[r];
      end
    end
  end

endmodule
`default_nettype wire

[test/tb.sv]
`default_nettype none
module tb;
  import dsed_pkg::*;

  localparam int IDLE_PCT     = 6;     // idle / stall chance per cycle, in percent
  localparam int RANDOM_WORDS = 900;   // size of the random small-image part
  localparam int TAIL_WORDS   = 150;   // words in each of the two closing phases
  localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake before giving up
  localparam int CALM_FIRST   = 500;   // cycle window with no idling on either side
  localparam int CALM_LAST    = 900;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // content styles of a random image
  typedef enum int {
    TEX_NOISE,  // full-range random samples
    TEX_FLAT,   // tiny range, lots of ties
    TEX_MIXED   // per-pixel mix of noise, ties and rail values
  } texture_t;

  // one input word: three layer samples plus the frame marker
  typedef struct packed {
    logic    fs;
    triple_t px;
  } pixel_word_t;

  // one result word
  typedef struct packed {
    logic                    found;
    logic                    cvalid;
    logic [OUT_POS_BITS-1:0] row;
    logic [OUT_POS_BITS-1:0] col;
  } verdict_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  cfg_reg_t                      cfg_index;
  logic [CFG_BITS-1:0]           cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_layer_below;
  logic signed [SAMPLE_BITS-1:0] in_layer_middle;
  logic signed [SAMPLE_BITS-1:0] in_layer_above;
  logic                          in_frame_start;
  logic                          out_valid;
  logic                          out_stall;
  logic                          out_extremum_found;
  logic                          out_centre_valid;
  logic [OUT_POS_BITS-1:0]       out_centre_row;
  logic [OUT_POS_BITS-1:0]       out_centre_column;

  dog_scale_space_extremum_detect_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_layer_below     (in_layer_below),
    .in_layer_middle    (in_layer_middle),
    .in_layer_above     (in_layer_above),
    .in_frame_start     (in_frame_start),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_extremum_found (out_extremum_found),
    .out_centre_valid   (out_centre_valid),
    .out_centre_row     (out_centre_row),
    .out_centre_column  (out_centre_column)
  );

  // stimulus and expectations
  pixel_word_t pending_pixels[$];    // words waiting to be driven
  verdict_t    expected_verdicts[$]; // predicted results, oldest first
  pixel_word_t on_port;              // word currently on the input ports
  pixel_word_t next_pixel;
  verdict_t    got_verdict;
  verdict_t    want_verdict;

  int unsigned words_queued;
  int unsigned words_taken;
  int unsigned verdicts_checked;
  int unsigned extrema_seen;
  int unsigned phases_run;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned quiet_cycles;

  // shadow of the detector: line stores, window, position counters, image size
  triple_t             line_mem [2*MAX_WIDTH];
  triple_t             win [3][3];  // [row: oldest first][column: oldest first]
  int unsigned         col_pos;
  int unsigned         row_pos;
  logic [CFG_BITS-1:0] width_reg;
  logic [CFG_BITS-1:0] height_reg;

  // idling is switched off inside one long stretch of the run
  wire calm = (cycle_count >= CALM_FIRST) && (cycle_count < CALM_LAST);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // centre test over the 27 window samples; ties never disqualify
  function automatic bit centre_is_peak();
    logic signed [SAMPLE_BITS-1:0] ctr;
    logic signed [SAMPLE_BITS-1:0] s [3];
    ctr = win[1][1].middle;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        s[0] = win[r][c].below;
        s[1] = win[r][c].middle;
        s[2] = win[r][c].above;
        for (int l = 0; l < 3; l++) begin
          if (ctr > 0) begin
            if (s[l] > ctr) return 1'b0;
          end else if (s[l] < ctr) begin
            return 1'b0;
          end
        end
      end
    end
    return 1'b1;
  endfunction

  // advance the shadow by one accepted word and return its verdict
  function automatic verdict_t predict_verdict(pixel_word_t w);
    int unsigned wd;
    int unsigned ht;
    int unsigned col;
    int unsigned row;
    triple_t     mid;
    triple_t     top;
    verdict_t    v;
    // out-of-range sizes are pinned to what the hardware can do
    wd = width_reg;
    if (wd < 3) wd = 3;
    if (wd > MAX_WIDTH) wd = MAX_WIDTH;
    ht = height_reg;
    if (ht < 3) ht = 3;

    // frame marker restarts the counters, stores and window are kept
    if (w.fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= wd) col_pos = 0;
    if (row_pos >= ht) row_pos = 0;
    col = col_pos;
    row = row_pos;

    // line one back moves to the older store, new pixel goes into the newer
    mid = line_mem[col];
    top = line_mem[MAX_WIDTH + col];
    line_mem[MAX_WIDTH + col] = mid;
    line_mem[col] = w.px;

    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = w.px;

    // border positions give an all-zero verdict
    v = '0;
    if (row >= 2 && col >= 2) begin
      v.found  = centre_is_peak();
      v.cvalid = 1'b1;
      v.row    = OUT_POS_BITS'(row - 1);
      v.col    = OUT_POS_BITS'(col - 1);
    end

    // raster wrap: last column, then last row
    col_pos = col + 1;
    if (col_pos >= wd) begin
      col_pos = 0;
      row_pos = row + 1;
      if (row_pos >= ht) row_pos = 0;
    end
    return v;
  endfunction

  function automatic pixel_word_t triple_word(logic signed [SAMPLE_BITS-1:0] b,
                                              logic signed [SAMPLE_BITS-1:0] m,
                                              logic signed [SAMPLE_BITS-1:0] a,
                                              logic fs);
    pixel_word_t w;
    w.fs        = fs;
    w.px.below  = b;
    w.px.middle = m;
    w.px.above  = a;
    return w;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rail_sample();
    case ($urandom_range(4))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3:       return SAMPLE_BITS'(1);
      default: return SAMPLE_BITS'(-1);
    endcase
  endfunction

  function automatic pixel_word_t make_pixel(texture_t tex, logic fs);
    logic signed [SAMPLE_BITS-1:0] s [3];
    int unsigned                   pick;
    for (int l = 0; l < 3; l++) begin
      pick = $urandom_range(99);
      if (tex == TEX_NOISE || (tex == TEX_MIXED && pick < 50)) begin
        s[l] = SAMPLE_BITS'($urandom);
      end else if (tex == TEX_FLAT || pick < 85) begin
        s[l] = SAMPLE_BITS'(int'($urandom_range(6)) - 3);
      end else begin
        s[l] = rail_sample();
      end
    end
    return triple_word(s[0], s[1], s[2], fs);
  endfunction

  task automatic push_pixel(pixel_word_t w);
    pending_pixels.push_back(w);
    words_queued++;
  endtask

  // block is idle once every queued word went in and every verdict came out
  task automatic wait_idle();
    while (words_taken != words_queued || expected_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // both size registers, back to back, only while idle
  task automatic write_dims(logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
    width_reg  = w;
    height_reg = h;
    phases_run++;
  endtask

  // one image stream of n words; first word carries the frame marker,
  // a rare stray marker breaks the frame somewhere in the middle
  task automatic random_image(int unsigned n, texture_t tex);
    for (int unsigned i = 0; i < n; i++) begin
      push_pixel(make_pixel(tex, (i == 0) || ($urandom_range(99) == 0)));
    end
  endtask

  function automatic logic [CFG_BITS-1:0] pick_width();
    case ($urandom_range(9))
      0:       return CFG_BITS'($urandom_range(2));  // below minimum, acts as three
      1: begin
        case ($urandom_range(2))
          0:       return CFG_BITS'(MAX_WIDTH);
          1:       return CFG_BITS'(MAX_WIDTH + 1);
          default: return '1;
        endcase
      end
      2:       return CFG_BITS'($urandom_range(11, 40));
      default: return CFG_BITS'($urandom_range(3, 10));
    endcase
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_height();
    case ($urandom_range(9))
      0:       return CFG_BITS'($urandom_range(2));
      1, 2:    return CFG_BITS'($urandom_range(7, 4095));
      default: return CFG_BITS'($urandom_range(3, 6));
    endcase
  endfunction

  // input driver: takes a word off the queue when the port is free, idling at random outside the calm stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_verdicts.push_back(predict_verdict(on_port));
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_pixels.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          next_pixel = pending_pixels.pop_front();
          on_port         <= next_pixel;
          in_layer_below  <= next_pixel.px.below;
          in_layer_middle <= next_pixel.px.middle;
          in_layer_above  <= next_pixel.px.above;
          in_frame_start  <= next_pixel.fs;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: random back-pressure, in-order compare
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_verdict = {out_extremum_found, out_centre_valid, out_centre_row, out_centre_column};
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result word: found %b valid %b row %0d col %0d",
                     got_verdict.found, got_verdict.cvalid, got_verdict.row, got_verdict.col);
          end
        end else begin
          want_verdict = expected_verdicts.pop_front();
          if (got_verdict.found !== want_verdict.found ||
              got_verdict.cvalid !== want_verdict.cvalid ||
              got_verdict.row !== want_verdict.row ||
              got_verdict.col !== want_verdict.col) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("verdict mismatch #%0d: expected found %b valid %b row %0d col %0d,",
                       verdicts_checked, want_verdict.found, want_verdict.cvalid,
                       want_verdict.row, want_verdict.col);
              $display("  actual found %b valid %b row %0d col %0d",
                       got_verdict.found, got_verdict.cvalid, got_verdict.row, got_verdict.col);
            end
          end
        end
        verdicts_checked++;
        if (out_extremum_found === 1'b1) extrema_seen++;
      end
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no handshake for %0d cycles, %0d verdicts outstanding",
               quiet_cycles, expected_verdicts.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned random_words;
    int unsigned n;
    texture_t    tex;

    // known values on every input from time zero
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_WIDTH;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_layer_below  = '0;
    in_layer_middle = '0;
    in_layer_above  = '0;
    in_frame_start  = 1'b0;
    out_stall       = 1'b0;
    on_port         = '0;
    words_queued     = 0;
    words_taken      = 0;
    verdicts_checked = 0;
    extrema_seen     = 0;
    phases_run       = 0;
    mismatches       = 0;
    cycle_count      = 0;
    quiet_cycles     = 0;
    random_words     = 0;

    // shadow reset: stores read as zero, window zero, counters at origin
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[r, c]) win[r][c] = '0;
    col_pos    = 0;
    row_pos    = 0;
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: smallest image, 3x3
    write_dims(CFG_BITS'(3), CFG_BITS'(3));
    // positive centre one below its rail-valued neighbours, not a peak
    for (int i = 0; i < 9; i++) begin
      push_pixel(triple_word(SAMPLE_MAX, (i == 4) ? SAMPLE_BITS'(SAMPLE_MAX - 1) : SAMPLE_MAX,
                             SAMPLE_MAX, i == 0));
    end
    // frame broken after three pixels by a new frame marker
    push_pixel(triple_word(SAMPLE_BITS'(1), SAMPLE_BITS'(-1), '0, 1'b1));
    push_pixel(triple_word(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1'b0));
    push_pixel(triple_word(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b0));
    // all samples at the negative rail: minimum by ties
    for (int i = 0; i < 9; i++) begin
      push_pixel(triple_word(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, i == 0));
    end
    // no marker: row counter wraps into the next frame
    push_pixel(triple_word('0, SAMPLE_BITS'(1), SAMPLE_BITS'(-1), 1'b0));
    push_pixel(triple_word(SAMPLE_BITS'(-1), '0, SAMPLE_BITS'(1), 1'b0));
    push_pixel(triple_word('0, '0, '0, 1'b0));
    wait_idle();

    // random small images with all kinds of sizes and content
    while (random_words < RANDOM_WORDS) begin
      n   = $urandom_range(40, 200);
      tex = texture_t'($urandom_range(2));
      write_dims(pick_width(), pick_height());
      random_image(n, tex);
      random_words += n;
      wait_idle();
    end

    // oversize width clamps to the maximum, height zero acts as three
    write_dims('1, '0);
    random_image(TAIL_WORDS, TEX_MIXED);
    wait_idle();

    // tall frame on a narrow image, many short rows
    write_dims(CFG_BITS'(3), '1);
    random_image(TAIL_WORDS, TEX_MIXED);
    wait_idle();

    repeat (10) @(posedge clk);

    $display("ran %0d image phases, %0d words in, %0d verdicts checked, %0d extrema flagged",
             phases_run, words_taken, verdicts_checked, extrema_seen);
    $display("%0d mismatches over %0d cycles", mismatches, cycle_count);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
